>>> src/assert_macros.svh
// Assertion helper macros shared by the RTL files of the disk request scheduler.
// Each macro expands to one labeled concurrent assertion with reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever pre holds, con holds at the same edge.
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
        else $error(msg);

// Next-cycle implication: whenever pre holds, con holds at the following edge.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
        else $error(msg);

`endif

>>> src/clook_pkg.sv
// Shared constants for the C-LOOK disk request scheduler.
// No dependencies; used by the scheduler top level and the testbench.
`default_nettype none

package clook_pkg;

    localparam int CYL_W     = 8;   // cylinder number width
    localparam int DIST_W    = 8;   // single seek distance width
    localparam int TOTAL_W   = 10;  // running total width
    localparam int S_TDATA_W = 8;   // request stream payload
    localparam int M_TDATA_W = 32;  // result stream payload, padded to bytes
    localparam int M_PAD_W   = M_TDATA_W - CYL_W - DIST_W - TOTAL_W - 1;

endpackage

`default_nettype wire

>>> src/clook_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read, read-first on a colliding write.
`default_nettype none

module clook_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/clook_disk_request_scheduler_unit.sv
// Top level of the C-LOOK disk request scheduler.
// Depends on clook_pkg, clook_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// C-LOOK disk request scheduler. Cylinder requests arrive on the slave stream,
// one transfer per cycle while tready is high, and are marked in a
// one-bit-per-cylinder pending map held in a synchronous RAM. A request's map
// bit is read into the load stage, then checked and written back; a write
// forward covers back-to-back requests for the same cylinder. Duplicates
// merge, and requests beyond MAX_REQUESTS or at or above CYLINDERS are dropped
// and reported through the dropped flag of every result of that batch. The
// transfer with tlast set ends the batch: after it the block stops taking
// requests and sweeps the map, first upward from the start_head register to
// the highest request, then from the lowest request up to the head. The sweep
// scans one cylinder per cycle through the RAM read port, covering the
// cylinders from the lower of the head and the lowest request up to the
// highest request; each hit stalls only while the master side holds tready
// low. Each served cylinder leaves as one master transfer with its seek
// distance and the running total; the last one carries tlast. Served entries
// are cleared as they go, so the map is empty for the next batch. After reset
// the block clears all min(CYLINDERS, 256) map entries before it takes the
// first request; configuration writes are taken at any time, but start_head
// must only change while the block is idle.
module clook_disk_request_scheduler_unit #(
    parameter int CYLINDERS    = 256,
    parameter int MAX_REQUESTS = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration: start_head
    input  wire logic                           i_cfg_we,
    input  wire logic [clook_pkg::CYL_W-1:0]    i_cfg_wdata,
    // Request stream
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // [7:0] request_cylinder
    input  wire logic [clook_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  wire logic                           i_s_tlast,      // batch_last
    // Result stream
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // [7:0] served_cylinder, [15:8] seek_distance, [25:16] running seek total,
    // [26] dropped_flag, [31:27] zero
    output logic [clook_pkg::M_TDATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tlast       // sweep_last
);

    import clook_pkg::*;

    // The map never needs more entries than an 8-bit cylinder can address.
    localparam int MAP_DEPTH = (CYLINDERS < 256) ? CYLINDERS : 256;
    localparam int AW        = $clog2(MAP_DEPTH);
    localparam int CNT_W     = $clog2(MAX_REQUESTS + 1);

    typedef enum logic [1:0] {
        ST_CLEAR,   // clearing pass after reset
        ST_LOAD,    // taking requests
        ST_PREP,    // batch closed, set up the sweep
        ST_SWEEP    // scanning the map and emitting results
    } t_state;

    typedef enum logic {
        PASS_UP,
        PASS_WRAP
    } t_pass;

    t_state             r_state;
    logic [AW-1:0]      r_clr;
    logic [CYL_W-1:0]   r_start_head;

    // Batch state
    logic [CNT_W-1:0]   r_count;
    logic [CYL_W-1:0]   r_low;
    logic [CYL_W-1:0]   r_high;
    logic               r_ovf;

    // Load stage: request whose map bit is being read
    logic               r_s2_valid;
    logic [CYL_W-1:0]   r_s2_cyl;
    logic               r_s2_last;
    logic               r_fwd_valid;
    logic [CYL_W-1:0]   r_fwd_cyl;

    // Sweep
    t_pass              r_pass;
    logic [CYL_W-1:0]   r_scan_addr;
    logic               r_sd_valid;
    logic [CYL_W-1:0]   r_sd_addr;
    logic [CYL_W-1:0]   r_pos;
    logic [TOTAL_W-1:0] r_total;
    logic [CNT_W-1:0]   r_served;

    // Output register
    logic               r_out_valid;
    logic [CYL_W-1:0]   r_out_cyl;
    logic [DIST_W-1:0]  r_out_dist;
    logic [TOTAL_W-1:0] r_out_total;
    logic               r_out_ovf;
    logic               r_out_last;

    // RAM ports
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic               ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic               ram_rdata;

    // Combinational helpers
    logic               s_hs;
    logic               s2_in_range;
    logic               s2_pending;
    logic               s2_take;
    logic               s2_drop;
    logic               up_ok;
    logic               wrap_ok;
    logic               can_issue;
    logic               hit;
    logic               last_hit;
    logic               out_free;
    logic               advance;
    logic               finish;
    logic               issue;
    logic [DIST_W-1:0]  hit_dist;
    logic [TOTAL_W-1:0] hit_total;

    assign o_s_tready = (r_state == ST_LOAD) && !(r_s2_valid && r_s2_last);
    assign s_hs       = i_s_tvalid && o_s_tready;

    // A request checks the map bit read last cycle, plus the write that landed
    // in the same edge as that read.
    always_comb begin
        s2_in_range = (32'(r_s2_cyl) < CYLINDERS);
        s2_pending  = ram_rdata || (r_fwd_valid && (r_fwd_cyl == r_s2_cyl));
        s2_take     = r_s2_valid && s2_in_range && !s2_pending
                      && (r_count < CNT_W'(MAX_REQUESTS));
        s2_drop     = r_s2_valid && (!s2_in_range
                      || (!s2_pending && (r_count >= CNT_W'(MAX_REQUESTS))));
    end

    // Sweep scan. Every pending cylinder lies within [low, high], so both
    // passes are bounded by the highest request.
    always_comb begin
        up_ok     = (r_scan_addr <= r_high);
        wrap_ok   = (r_scan_addr < r_start_head) && (r_scan_addr <= r_high);
        can_issue = (r_pass == PASS_UP) ? up_ok : wrap_ok;
        hit       = (r_state == ST_SWEEP) && r_sd_valid && ram_rdata;
        last_hit  = hit && ((r_served + CNT_W'(1)) == r_count);
        out_free  = !r_out_valid || i_m_tready;
        advance   = !hit || out_free;
        finish    = last_hit && advance;
        issue     = (r_state == ST_SWEEP) && advance && can_issue && !finish;
        hit_dist  = (r_sd_addr >= r_pos) ? (r_sd_addr - r_pos) : (r_pos - r_sd_addr);
        hit_total = r_total + TOTAL_W'(hit_dist);
    end

    // RAM port selection.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_s2_cyl[AW-1:0];
        ram_wdata = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            ST_LOAD: begin
                ram_we    = s2_take;
                ram_wdata = 1'b1;
            end
            ST_SWEEP: begin
                ram_we    = hit && advance;
                ram_waddr = r_sd_addr[AW-1:0];
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
        if (r_state == ST_SWEEP) begin
            ram_raddr = r_scan_addr[AW-1:0];
            ram_re    = issue;
        end else begin
            ram_raddr = i_s_tdata[AW-1:0];
            ram_re    = s_hs;
        end
    end

    clook_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_head <= '0;
        end else if (i_cfg_we) begin
            r_start_head <= i_cfg_wdata;
        end
    end

    // Main state machine and its registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_low       <= '0;
            r_high      <= '0;
            r_ovf       <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_sd_valid  <= 1'b0;
            r_pass      <= PASS_UP;
            r_out_valid <= 1'b0;
        end else begin
            // The output register empties when taken, unless a new hit refills it.
            if (i_m_tready && !(hit && advance)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(MAP_DEPTH - 1)) begin
                        r_state <= ST_LOAD;
                        r_low   <= r_start_head;
                        r_high  <= r_start_head;
                    end
                end
                ST_LOAD: begin
                    r_s2_valid  <= s_hs;
                    r_s2_cyl    <= i_s_tdata[CYL_W-1:0];
                    r_s2_last   <= i_s_tlast;
                    r_fwd_valid <= s2_take;
                    r_fwd_cyl   <= r_s2_cyl;
                    if (s2_take) begin
                        r_count <= r_count + CNT_W'(1);
                        if (r_count == '0) begin
                            r_low  <= r_s2_cyl;
                            r_high <= r_s2_cyl;
                        end else begin
                            if (r_s2_cyl < r_low) begin
                                r_low <= r_s2_cyl;
                            end
                            if (r_s2_cyl > r_high) begin
                                r_high <= r_s2_cyl;
                            end
                        end
                    end
                    if (s2_drop) begin
                        r_ovf <= 1'b1;
                    end
                    // tready is low here, so the load stage empties by itself.
                    if (r_s2_valid && r_s2_last) begin
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_fwd_valid <= 1'b0;
                    r_scan_addr <= r_start_head;
                    r_pass      <= PASS_UP;
                    r_pos       <= r_start_head;
                    r_total     <= '0;
                    r_served    <= '0;
                    r_sd_valid  <= 1'b0;
                    if (r_count == '0) begin
                        // Empty batch: nothing to serve.
                        r_state <= ST_LOAD;
                        r_ovf   <= 1'b0;
                        r_low   <= r_start_head;
                        r_high  <= r_start_head;
                    end else begin
                        r_state <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    if (hit && advance) begin
                        r_out_valid <= 1'b1;
                        r_out_cyl   <= r_sd_addr;
                        r_out_dist  <= hit_dist;
                        r_out_total <= hit_total;
                        r_out_ovf   <= r_ovf;
                        r_out_last  <= last_hit;
                        r_pos       <= r_sd_addr;
                        r_total     <= hit_total;
                        r_served    <= r_served + CNT_W'(1);
                    end
                    if (finish) begin
                        // Every pending cylinder served and cleared.
                        r_state    <= ST_LOAD;
                        r_sd_valid <= 1'b0;
                        r_count    <= '0;
                        r_ovf      <= 1'b0;
                        r_low      <= r_start_head;
                        r_high     <= r_start_head;
                    end else if (advance) begin
                        r_sd_valid <= issue;
                        r_sd_addr  <= r_scan_addr;
                        if (r_pass == PASS_UP) begin
                            if (up_ok && (r_scan_addr != r_high)) begin
                                r_scan_addr <= r_scan_addr + CYL_W'(1);
                            end else begin
                                r_pass      <= PASS_WRAP;
                                r_scan_addr <= r_low;
                            end
                        end else if (wrap_ok) begin
                            r_scan_addr <= r_scan_addr + CYL_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {M_PAD_W'(0), r_out_ovf, r_out_total, r_out_dist, r_out_cyl};
    assign o_m_tlast  = r_out_last;

    // The load stage only ever holds a request while requests are taken.
    `ASSERT_IMPLIES(a_s2_in_load, i_clk, i_rst_n, r_s2_valid, r_state == ST_LOAD,
        "load stage busy outside the load state")

    // During the sweep the map is only ever cleared, never set.
    `ASSERT_IMPLIES(a_sweep_clears, i_clk, i_rst_n, (r_state == ST_SWEEP) && ram_we,
        !ram_wdata, "sweep wrote a set bit into the map")

    // A sweep never serves more cylinders than were accepted.
    `ASSERT_IMPLIES(a_served_bound, i_clk, i_rst_n, r_state == ST_SWEEP,
        r_served < r_count, "sweep served more than the batch held")

    // The final result of a sweep hands control back to request loading.
    `ASSERT_NEXT(a_finish_to_load, i_clk, i_rst_n, finish, r_state == ST_LOAD,
        "sweep did not return to loading after its last result")

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for clook_disk_request_scheduler_unit.
// Depends on clook_pkg and the scheduler RTL; predicts every served cylinder itself.
`timescale 1ns / 100ps

module tb_top;
    import clook_pkg::*;

    // Predictor limits, matching the block's default parameters.
    localparam int CYL_COUNT     = 256;
    localparam int REQUEST_SLOTS = 64;
    // Cycles allowed after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 16;
    // Hard limit on the run.
    localparam int CYCLE_LIMIT   = 400000;

    // One served cylinder as the block should report it.
    typedef struct {
        logic [CYL_W-1:0]   cyl;
        logic [DIST_W-1:0]  seek;
        logic [TOTAL_W-1:0] total;
        logic               dropped;
        logic               last;
    } t_service;

    // Clock, reset and every block input start at a known value.
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CYL_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]   i_s_tdata   = '0;    // [7:0] request_cylinder
    logic                   i_s_tlast   = 1'b0;  // batch_last
    logic                   i_m_tready  = 1'b0;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [M_TDATA_W-1:0]   o_m_tdata;           // [7:0] cylinder, [15:8] seek,
                                                 // [25:16] total, [26] dropped
    logic                   o_m_tlast;           // sweep_last

    clook_disk_request_scheduler_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Scheduler predictor: its own pending map, bounds and head register.
    // ------------------------------------------------------------------
    bit               pending_cyl [CYL_COUNT];
    int unsigned      queued_count   = 0;
    logic [CYL_W-1:0] low_cyl        = '0;
    logic [CYL_W-1:0] high_cyl       = '0;
    bit               batch_dropped  = 1'b0;
    logic [CYL_W-1:0] head_cyl       = '0;    // start_head after reset

    // Served cylinders still owed by the block, oldest first.
    t_service         served_q[$];

    // Run statistics for the closing summary.
    int unsigned      mismatches     = 0;
    int unsigned      requests_sent  = 0;
    int unsigned      batches_swept  = 0;
    int unsigned      dropped_batches = 0;
    int unsigned      results_seen   = 0;
    int unsigned      head_writes    = 0;
    int unsigned      cycle_count    = 0;

    // When set, neither side inserts idle cycles.
    bit               steady_flow    = 1'b0;
    int unsigned      stall_left     = 0;

    // Load one request into the pending map. Duplicates merge silently; a new
    // cylinder beyond capacity is dropped and marks the whole batch.
    function automatic void mark_request(logic [CYL_W-1:0] cyl);
        if (pending_cyl[cyl])
            return;
        if (queued_count >= REQUEST_SLOTS) begin
            batch_dropped = 1'b1;
            return;
        end
        if (queued_count == 0) begin
            low_cyl  = cyl;
            high_cyl = cyl;
        end else begin
            if (cyl < low_cyl)
                low_cyl = cyl;
            if (cyl > high_cyl)
                high_cyl = cyl;
        end
        pending_cyl[cyl] = 1'b1;
        queued_count++;
    endfunction

    // Work out the C-LOOK order for the finished batch and queue the results,
    // then return the predictor to an empty batch.
    function automatic void plan_sweep();
        logic [CYL_W-1:0]   order[$];
        logic [CYL_W-1:0]   pos;
        logic [DIST_W-1:0]  step_len;
        logic [TOTAL_W-1:0] total;
        t_service           entry;
        int                 c;

        pos   = head_cyl;
        total = '0;
        // Upward pass from the head to the highest request.
        for (c = int'(head_cyl); c <= int'(high_cyl); c++)
            if (pending_cyl[c])
                order.insert(order.size(), CYL_W'(c));
        // Jump back to the lowest request and go up to just below the head.
        for (c = int'(low_cyl); c < int'(head_cyl); c++)
            if (pending_cyl[c])
                order.insert(order.size(), CYL_W'(c));

        foreach (order[i]) begin
            step_len      = (order[i] >= pos) ? order[i] - pos : pos - order[i];
            total         = total + TOTAL_W'(step_len);
            pos           = order[i];
            entry.cyl     = order[i];
            entry.seek    = step_len;
            entry.total   = total;
            entry.dropped = batch_dropped;
            entry.last    = (i == order.size() - 1);
            served_q.insert(served_q.size(), entry);
        end

        batches_swept++;
        if (batch_dropped)
            dropped_batches++;
        foreach (pending_cyl[i])
            pending_cyl[i] = 1'b0;
        queued_count  = 0;
        low_cyl       = head_cyl;
        high_cyl      = head_cyl;
        batch_dropped = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Idle-length helpers: mostly short gaps, now and then a long one.
    // ------------------------------------------------------------------
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int sender_gap();
        if (steady_flow || $urandom_range(0, 1) == 0)
            return 0;
        return idle_length();
    endfunction

    // ------------------------------------------------------------------
    // Result side: random backpressure on tready.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
            stall_left <= idle_length() - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker. Each accepted transfer is compared field by field
    // against the oldest outstanding prediction.
    // ------------------------------------------------------------------
    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_service want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (served_q.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected result, expected none, got tdata=%h tlast=%b",
                         $time, o_m_tdata, o_m_tlast);
            end else begin
                want = served_q.pop_front();
                check_field("served_cylinder", 32'(want.cyl), 32'(o_m_tdata[7:0]));
                check_field("seek_distance", 32'(want.seek), 32'(o_m_tdata[15:8]));
                check_field("seek_total", 32'(want.total), 32'(o_m_tdata[25:16]));
                check_field("dropped_flag", 32'(want.dropped), 32'(o_m_tdata[26]));
                check_field("sweep_last", 32'(want.last), 32'(o_m_tlast));
            end
        end
    end

    // Watchdog: a hung block or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, served_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus primitives.
    // ------------------------------------------------------------------

    // Present one request and hold it until the transfer completes. tvalid is
    // only lowered when a gap is taken, so back-to-back requests never see a
    // low and a high assignment in the same time step.
    task automatic send_request(input logic [CYL_W-1:0] cyl, input logic last);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= cyl;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        requests_sent++;
        mark_request(cyl);
        if (last)
            plan_sweep();
    endtask

    // Stop sending, wait for every predicted result, then let the block settle.
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (served_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write start_head; only called while the block is idle.
    task automatic write_start_head(input logic [CYL_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        head_cyl     = value;
        head_writes++;
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // First batch runs with the head left at its reset position of zero,
    // including a request at cylinder zero itself.
    task automatic test_reset_head();
        send_request(8'd5, 1'b0);
        send_request(8'd0, 1'b1);
    endtask

    // Cylinders and head at both ends of the range: the longest single seek,
    // a zero seek, and a head above every request.
    task automatic test_field_extremes();
        send_request(8'd255, 1'b1);
        wait_for_results();
        write_start_head(8'd255);
        send_request(8'd255, 1'b1);
        send_request(8'd0, 1'b1);
    endtask

    // Requests on both sides of the head, right next to it, and at the ends,
    // so the sweep runs up, wraps to the bottom and climbs back.
    task automatic test_wrap_order();
        wait_for_results();
        write_start_head(8'd128);
        send_request(8'd200, 1'b0);
        send_request(8'd30, 1'b0);
        send_request(8'd129, 1'b0);
        send_request(8'd127, 1'b0);
        send_request(8'd255, 1'b0);
        send_request(8'd0, 1'b1);
    endtask

    // Head above every request: the upward pass is empty and the sweep
    // starts straight at the lowest request.
    task automatic test_head_beyond();
        wait_for_results();
        write_start_head(8'd200);
        send_request(8'd10, 1'b0);
        send_request(8'd50, 1'b0);
        send_request(8'd199, 1'b1);
    endtask

    // Duplicates back to back and apart, and a duplicate carrying tlast.
    task automatic test_duplicates();
        wait_for_results();
        write_start_head(8'd60);
        send_request(8'd70, 1'b0);
        send_request(8'd70, 1'b0);
        send_request(8'd40, 1'b0);
        send_request(8'd70, 1'b0);
        send_request(8'd40, 1'b1);
    endtask

    // Capacity edge. One batch fills every slot with no idling on either
    // side, then repeats a cylinder, which must merge and not be served twice,
    // and ends on a new cylinder that must be dropped and flagged.
    task automatic test_capacity_limits();
        logic [CYL_W-1:0] base;
        logic [CYL_W-1:0] stride;
        int               i;

        wait_for_results();
        write_start_head(CYL_W'($urandom_range(0, 255)));
        base        = CYL_W'($urandom_range(0, 255));
        stride      = CYL_W'($urandom_range(0, 127) * 2 + 1);  // odd: all distinct
        steady_flow = 1'b1;
        for (i = 0; i < REQUEST_SLOTS; i++)
            send_request(base + CYL_W'(i) * stride, 1'b0);
        send_request(base + CYL_W'(3) * stride, 1'b0);
        send_request(base + CYL_W'(REQUEST_SLOTS) * stride, 1'b1);
        wait_for_results();
        steady_flow = 1'b0;
    endtask

    // Random batches, mostly short with the odd longer one. Content mixes
    // uniform cylinders, repeats of the previous request and cylinders close
    // to the head. Some batches follow straight on; before others the sender
    // pauses until every result is back and the head is moved.
    task automatic test_random_batches();
        int               sent;
        int               size;
        int               i;
        logic [CYL_W-1:0] cyl;
        logic [CYL_W-1:0] prev;

        sent = 0;
        prev = '0;
        while (sent < 35) begin
            if ($urandom_range(0, 2) == 0) begin
                wait_for_results();
                case ($urandom_range(0, 4))
                    0:       write_start_head(8'd0);
                    1:       write_start_head(8'd255);
                    default: write_start_head(CYL_W'($urandom_range(0, 255)));
                endcase
            end
            steady_flow = ($urandom_range(0, 5) == 0);
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
            for (i = 0; i < size; i++) begin
                case ($urandom_range(0, 9))
                    0, 1:    cyl = (i > 0) ? prev : CYL_W'($urandom_range(0, 255));
                    2, 3:    cyl = head_cyl + CYL_W'($urandom_range(0, 6)) - CYL_W'(3);
                    default: cyl = CYL_W'($urandom_range(0, 255));
                endcase
                send_request(cyl, i == size - 1);
                prev = cyl;
            end
            sent += size;
        end
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequencing: reset once, run the tests in turn, drain and report.
    // ------------------------------------------------------------------
    initial begin : run_tests
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_head();
        test_field_extremes();
        test_wrap_order();
        test_head_beyond();
        test_duplicates();
        test_capacity_limits();
        test_random_batches();

        wait_for_results();
        $display("Swept %0d batches from %0d requests, checked %0d served cylinders.",
                 batches_swept, requests_sent, results_seen);
        $display("Head moved %0d times; %0d batches lost requests to the capacity limit.",
                 head_writes, dropped_batches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
